[rtl/dsli_pkg.sv]
// Package for the decade segmented linear interpolator: types, thresholds and helpers.
`timescale 1ns / 1ps

package dsli_pkg;

  localparam int unsigned Q_W   = 31;
  localparam int unsigned V_W   = 32;
  localparam int unsigned EIX_W = 14;

  localparam int unsigned S_TDATA_W = 208;
  localparam int unsigned M_TDATA_W = 64;

  localparam logic [Q_W-1:0] Q_TINY_MAX = 31'd65;
  localparam logic [Q_W-1:0] Q_HUGE     = 31'd1456340992;
  localparam logic [Q_W-1:0] Q_2        = 31'd131072;
  localparam logic [Q_W-1:0] Q_22       = 31'd1441792;
  localparam logic [Q_W-1:0] Q_222      = 31'd14548992;
  localparam logic [Q_W-1:0] Q_2222     = 31'd145620992;

  localparam logic [40:0] RND_HALF_STEP = 41'd32768;
  localparam logic [40:0] RND_DECA      = 41'd327680;
  localparam logic [15:0] RECIP_TEN     = 16'd52429;

  typedef enum logic [2:0] {
    SEG_MILLI,
    SEG_CENTI,
    SEG_DECI,
    SEG_UNIT,
    SEG_DECA
  } seg_t;

  typedef struct packed {
    logic [Q_W-1:0] knot;
    logic [V_W-1:0] chi;
    logic [V_W-1:0] gamma;
    logic [V_W-1:0] chi_slope;
    logic [V_W-1:0] gamma_slope;
  } entry_t;

  typedef struct packed {
    logic             load;
    logic             tiny;
    logic             huge;
    logic [Q_W-1:0]   q;
    logic [EIX_W-1:0] index;
    entry_t           entry;
  } item_t;

  typedef struct packed {
    logic load;
    logic tiny;
    logic huge;
  } tag_t;

  function automatic logic [9:0] seg_mul(input seg_t seg);
    logic [9:0] m;
    case (seg)
      SEG_MILLI: m = 10'd1000;
      SEG_CENTI: m = 10'd100;
      SEG_DECI:  m = 10'd10;
      SEG_UNIT:  m = 10'd1;
      SEG_DECA:  m = 10'd1;
      default:   m = 10'd1;
    endcase
    return m;
  endfunction

  function automatic logic [Q_W-1:0] seg_start(input seg_t seg);
    logic [Q_W-1:0] s;
    case (seg)
      SEG_MILLI: s = '0;
      SEG_CENTI: s = Q_2;
      SEG_DECI:  s = Q_22;
      SEG_UNIT:  s = Q_222;
      SEG_DECA:  s = Q_2222;
      default:   s = '0;
    endcase
    return s;
  endfunction

  // value + rounded product, clamped to 32 bits; msb of result is the clamp flag
  function automatic logic [V_W:0] sat_add(input logic [47:0] rnd, input logic [V_W-1:0] value);
    logic [48:0] total;
    logic [V_W:0] res;
    total = {rnd[47], rnd} + {{17{value[V_W-1]}}, value};
    if (!total[48] && (total[47:31] != '0)) begin
      res = {1'b1, 1'b0, {(V_W-1){1'b1}}};
    end else if (total[48] && (total[47:31] != '1)) begin
      res = {1'b1, 1'b1, {(V_W-1){1'b0}}};
    end else begin
      res = {1'b0, total[V_W-1:0]};
    end
    return res;
  endfunction

endpackage

[rtl/decade_segmented_linear_interpolator_core.sv]
// Top level: pipelined decade-segmented table interpolator with table loading over the input stream.
`timescale 1ns / 1ps

// One item enters per cycle. A query result is written to the output register at the end of
// the pipeline; load items write one table entry and give no result. The whole
// pipeline holds while a result waits in the output register. The table is a single
// memory of 5*SEGMENT_POINTS+1 entries (knot, two values, two slopes) with one write and
// one registered read per cycle; its contents are undefined until loaded, and a query must
// only hit entries already written. Q at or below 0.001 returns small_q_chi and zero;
// Q at or above 22222 returns zeros.
module decade_segmented_linear_interpolator_core import dsli_pkg::*; #(
  parameter int unsigned SEGMENT_POINTS = 2000
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [V_W-1:0]       cfg_wdata,      // small_q_chi
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // q_value, entry_index, entry_knot, entry_chi, entry_gamma, entry_chi_slope,
  // entry_gamma_slope, zero pad
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic                 s_axis_tuser,   // mode
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // chi_out, gamma_out
  output logic                 m_axis_tuser    // saturated
);

  localparam int unsigned TABLE_DEPTH = 5 * SEGMENT_POINTS + 1;
  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned IDX_W = ((AW > 11) ? AW : 11) + 1;
  localparam logic [IDX_W-1:0] BASE1 = IDX_W'(SEGMENT_POINTS);
  localparam logic [IDX_W-1:0] BASE2 = IDX_W'(2 * SEGMENT_POINTS);
  localparam logic [IDX_W-1:0] BASE3 = IDX_W'(3 * SEGMENT_POINTS);
  localparam logic [IDX_W-1:0] BASE4 = IDX_W'(4 * SEGMENT_POINTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [AW+EIX_W-1:0] DEPTH_EXT = (AW + EIX_W)'(TABLE_DEPTH);

  logic en;
  logic [V_W-1:0] small_q_chi;

  logic v1, v2, v3, v4, v5, v6, v7, v8, v9;
  item_t it1, it2, it3, it4, it5;
  seg_t seg2, seg3, seg4;
  logic [Q_W-1:0] dq2;
  logic [14:0] t3;
  logic [10:0] rel4;
  logic [AW-1:0] addr5;
  tag_t tag6, tag7, tag8, tag9;
  logic [Q_W-1:0] q6;
  entry_t rd6;
  logic signed [V_W-1:0] dq7;
  entry_t ent7;
  logic signed [63:0] chi_prod8, gamma_prod8;
  logic [V_W-1:0] chi_val8, gamma_val8, chi_val9, gamma_val9;
  logic [47:0] chi_rnd9, gamma_rnd9;

  entry_t table_mem [TABLE_DEPTH];

  item_t in_item;
  seg_t seg1;
  logic [40:0] p2;
  logic [29:0] p3;
  logic [10:0] rel3;
  logic [IDX_W-1:0] sum4;
  logic [AW-1:0] addr4;
  logic [AW+EIX_W-1:0] wr_ext;
  logic signed [V_W-1:0] dq6;
  logic signed [63:0] chi_prod7, gamma_prod7;
  logic [63:0] chi_sum8, gamma_sum8;
  logic [V_W:0] chi_res9, gamma_res9;

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_comb begin
    in_item.load              = s_axis_tuser;
    in_item.q                 = s_axis_tdata[30:0];
    in_item.index             = s_axis_tdata[44:31];
    in_item.entry.knot        = s_axis_tdata[75:45];
    in_item.entry.chi         = s_axis_tdata[107:76];
    in_item.entry.gamma       = s_axis_tdata[139:108];
    in_item.entry.chi_slope   = s_axis_tdata[171:140];
    in_item.entry.gamma_slope = s_axis_tdata[203:172];
    in_item.tiny              = s_axis_tdata[30:0] <= Q_TINY_MAX;
    in_item.huge              = s_axis_tdata[30:0] >= Q_HUGE;
  end

  always_comb begin
    if (it1.q <= Q_2) begin
      seg1 = SEG_MILLI;
    end else if (it1.q <= Q_22) begin
      seg1 = SEG_CENTI;
    end else if (it1.q <= Q_222) begin
      seg1 = SEG_DECI;
    end else if (it1.q <= Q_2222) begin
      seg1 = SEG_UNIT;
    end else begin
      seg1 = SEG_DECA;
    end
  end

  assign p2 = 41'(dq2) * 41'(seg_mul(seg2))
            + ((seg2 == SEG_DECA) ? RND_DECA : RND_HALF_STEP);

  assign p3 = 30'(t3) * 30'(RECIP_TEN);
  assign rel3 = (seg3 == SEG_DECA) ? p3[29:19] : t3[10:0];

  always_comb begin
    sum4 = IDX_W'(rel4);
    case (seg4)
      SEG_MILLI: sum4 = IDX_W'(rel4);
      SEG_CENTI: sum4 = IDX_W'(rel4) + BASE1;
      SEG_DECI:  sum4 = IDX_W'(rel4) + BASE2;
      SEG_UNIT:  sum4 = IDX_W'(rel4) + BASE3;
      SEG_DECA:  sum4 = IDX_W'(rel4) + BASE4;
      default:   sum4 = IDX_W'(rel4);
    endcase
    addr4 = (sum4 > LAST_IDX) ? LAST_IDX[AW-1:0] : sum4[AW-1:0];
  end

  assign wr_ext = {{AW{1'b0}}, it5.index};

  assign dq6 = $signed({1'b0, q6}) - $signed({1'b0, rd6.knot});
  assign chi_prod7 = $signed(ent7.chi_slope) * dq7;
  assign gamma_prod7 = $signed(ent7.gamma_slope) * dq7;
  assign chi_sum8 = chi_prod8 + 64'sd32768;
  assign gamma_sum8 = gamma_prod8 + 64'sd32768;
  assign chi_res9 = sat_add(chi_rnd9, chi_val9);
  assign gamma_res9 = sat_add(gamma_rnd9, gamma_val9);

  always_ff @(posedge clk) begin
    if (rst) begin
      small_q_chi <= '0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
      v9 <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        small_q_chi <= cfg_wdata;
      end
      if (en) begin
        v1 <= s_axis_tvalid;
        v2 <= v1;
        v3 <= v2;
        v4 <= v3;
        v5 <= v4;
        v6 <= v5;
        v7 <= v6;
        v8 <= v7;
        v9 <= v8;
        m_axis_tvalid <= v9 && !tag9.load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it1 <= in_item;
      it2 <= it1;
      seg2 <= seg1;
      dq2 <= it1.q - seg_start(seg1);
      it3 <= it2;
      seg3 <= seg2;
      t3 <= p2[30:16];
      it4 <= it3;
      seg4 <= seg3;
      rel4 <= rel3;
      it5 <= it4;
      addr5 <= addr4;
      tag6 <= '{load: it5.load, tiny: it5.tiny, huge: it5.huge};
      q6 <= it5.q;
      rd6 <= table_mem[addr5];
      if (v5 && it5.load && (wr_ext < DEPTH_EXT)) begin
        table_mem[wr_ext[AW-1:0]] <= it5.entry;
      end
      tag7 <= tag6;
      dq7 <= dq6;
      ent7 <= rd6;
      tag8 <= tag7;
      chi_prod8 <= chi_prod7;
      gamma_prod8 <= gamma_prod7;
      chi_val8 <= ent7.chi;
      gamma_val8 <= ent7.gamma;
      tag9 <= tag8;
      chi_rnd9 <= chi_sum8[63:16];
      gamma_rnd9 <= gamma_sum8[63:16];
      chi_val9 <= chi_val8;
      gamma_val9 <= gamma_val8;
      if (tag9.tiny) begin
        m_axis_tdata <= {{V_W{1'b0}}, small_q_chi};
        m_axis_tuser <= 1'b0;
      end else if (tag9.huge) begin
        m_axis_tdata <= '0;
        m_axis_tuser <= 1'b0;
      end else begin
        m_axis_tdata <= {gamma_res9[V_W-1:0], chi_res9[V_W-1:0]};
        m_axis_tuser <= chi_res9[V_W] || gamma_res9[V_W];
      end
    end
  end

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the decade segmented linear interpolator core.
`timescale 1ns / 1ps

module tb_top;
  import dsli_pkg::*;

  localparam int unsigned SEG_PTS = 2000;
  localparam int unsigned DEPTH = 5 * SEG_PTS + 1;
  localparam logic MODE_QUERY = 1'b0;
  localparam logic MODE_LOAD = 1'b1;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_ITEMS = 195;
  localparam longint unsigned Q_ONE = 65536;

  typedef struct {
    logic [V_W-1:0] chi;
    logic [V_W-1:0] gamma;
    logic sat;
  } interp_result_t;

  class interp_scoreboard;
    logic [Q_W-1:0] knot_tab [DEPTH];
    logic [V_W-1:0] chi_tab [DEPTH];
    logic [V_W-1:0] gamma_tab [DEPTH];
    logic [V_W-1:0] chi_slope_tab [DEPTH];
    logic [V_W-1:0] gamma_slope_tab [DEPTH];
    bit written [DEPTH];
    logic [V_W-1:0] small_chi;
    interp_result_t pending_results [$];
    int errors;

    function new();
      small_chi = '0;
      errors = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    function void set_small_chi(logic [V_W-1:0] v);
      small_chi = v;
    endfunction

    function logic [EIX_W-1:0] table_index(logic [Q_W-1:0] q);
      longint unsigned start, mul, dv, base, idx;
      if (q <= Q_2) begin
        start = 0; mul = 1000; dv = 1; base = 0;
      end else if (q <= Q_22) begin
        start = Q_2; mul = 100; dv = 1; base = 1;
      end else if (q <= Q_222) begin
        start = Q_22; mul = 10; dv = 1; base = 2;
      end else if (q <= Q_2222) begin
        start = Q_222; mul = 1; dv = 1; base = 3;
      end else begin
        start = Q_2222; mul = 1; dv = 10; base = 4;
      end
      idx = ((longint'(q) - start) * 2 * mul + dv * Q_ONE) / (dv * 2 * Q_ONE) + base * SEG_PTS;
      if (idx >= DEPTH) idx = DEPTH - 1;
      return EIX_W'(idx);
    endfunction

    // msb is the clamp flag
    function logic [V_W:0] interpolate(logic [V_W-1:0] value, logic [V_W-1:0] slope,
                                       longint dq);
      longint prod, r;
      prod = longint'($signed(slope)) * dq;
      r = ((prod + 64'sd32768) >>> 16) + longint'($signed(value));
      if (r > 64'sd2147483647) return {1'b1, 32'h7FFF_FFFF};
      if (r < -64'sd2147483648) return {1'b1, 32'h8000_0000};
      return {1'b0, V_W'(r)};
    endfunction

    function void note_item(logic mode, logic [S_TDATA_W-1:0] data);
      logic [Q_W-1:0] q;
      logic [EIX_W-1:0] eidx, idx;
      interp_result_t res;
      logic [V_W:0] c, g;
      longint dq;
      q = data[30:0];
      eidx = data[44:31];
      if (mode == MODE_LOAD) begin
        if (eidx < DEPTH) begin
          knot_tab[eidx] = data[75:45];
          chi_tab[eidx] = data[107:76];
          gamma_tab[eidx] = data[139:108];
          chi_slope_tab[eidx] = data[171:140];
          gamma_slope_tab[eidx] = data[203:172];
          written[eidx] = 1'b1;
        end
        return;
      end
      if (q <= Q_TINY_MAX) begin
        res = '{small_chi, '0, 1'b0};
      end else if (q >= Q_HUGE) begin
        res = '{'0, '0, 1'b0};
      end else begin
        idx = table_index(q);
        dq = longint'(q) - longint'(knot_tab[idx]);
        c = interpolate(chi_tab[idx], chi_slope_tab[idx], dq);
        g = interpolate(gamma_tab[idx], gamma_slope_tab[idx], dq);
        res = '{c[V_W-1:0], g[V_W-1:0], c[V_W] | g[V_W]};
      end
      pending_results.push_back(res);
    endfunction

    task report_mismatch(string what, logic [V_W-1:0] got, logic [V_W-1:0] want);
      $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
      errors++;
    endtask

    task check_result(logic [M_TDATA_W-1:0] data, logic sat_bit);
      interp_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", data[31:0], '0);
        return;
      end
      want = pending_results.pop_front();
      if (data[31:0] !== want.chi) report_mismatch("chi_out", data[31:0], want.chi);
      if (data[63:32] !== want.gamma) report_mismatch("gamma_out", data[63:32], want.gamma);
      if (sat_bit !== want.sat) report_mismatch("saturated", V_W'(sat_bit), V_W'(want.sat));
    endtask
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [V_W-1:0] cfg_wdata;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;

  interp_scoreboard sb;
  bit tx_idle;
  bit rx_idle;
  logic [Q_W-1:0] last_q;

  decade_segmented_linear_interpolator_core #(
    .SEGMENT_POINTS(SEG_PTS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int unsigned idle_cycles(bit enabled);
    return enabled ? $urandom_range(5, 0) : 0;
  endfunction

  function automatic logic [S_TDATA_W-1:0] pack_item(logic [Q_W-1:0] q, logic [EIX_W-1:0] idx,
      logic [Q_W-1:0] knot, logic [V_W-1:0] chi, logic [V_W-1:0] gamma,
      logic [V_W-1:0] chi_slope, logic [V_W-1:0] gamma_slope);
    return {gamma_slope, chi_slope, gamma, chi, knot, idx, q};
  endfunction

  function automatic logic [V_W-1:0] rand_slope();
    if ($urandom_range(1, 0) != 0) return $urandom();
    return V_W'($urandom_range(2097151, 0)) - 32'd1048576;
  endfunction

  function automatic logic [Q_W-1:0] knot_near(logic [Q_W-1:0] q);
    longint k;
    if ($urandom_range(3, 0) == 0) return Q_W'($urandom());
    k = longint'(q) + longint'($urandom_range(131071, 0)) - 65536;
    if (k < 0) k = 0;
    if (k > 64'sd2147483647) k = 64'sd2147483647;
    return Q_W'(k);
  endfunction

  task automatic send_item(logic mode, logic [S_TDATA_W-1:0] data);
    int unsigned gap;
    gap = idle_cycles(tx_idle);
    @(negedge clk);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= data;
    s_axis_tuser <= mode;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_item(mode, data);
  endtask

  task automatic load_entry(logic [EIX_W-1:0] idx, logic [Q_W-1:0] knot, logic [V_W-1:0] chi,
      logic [V_W-1:0] gamma, logic [V_W-1:0] chi_slope, logic [V_W-1:0] gamma_slope);
    send_item(MODE_LOAD, pack_item(Q_W'($urandom()), idx, knot, chi, gamma, chi_slope,
                                   gamma_slope));
  endtask

  // loads the entry the query lands on first if it was never written
  task automatic query(logic [Q_W-1:0] q);
    logic [EIX_W-1:0] idx;
    if (q > Q_TINY_MAX && q < Q_HUGE) begin
      idx = sb.table_index(q);
      if (!sb.written[idx])
        load_entry(idx, knot_near(q), $urandom(), $urandom(), rand_slope(), rand_slope());
    end
    last_q = q;
    send_item(MODE_QUERY, pack_item(q, EIX_W'($urandom()), Q_W'($urandom()), $urandom(),
                                    $urandom(), $urandom(), $urandom()));
  endtask

  task automatic query_with_entry(logic [Q_W-1:0] q, logic [Q_W-1:0] knot, logic [V_W-1:0] chi,
      logic [V_W-1:0] gamma, logic [V_W-1:0] chi_slope, logic [V_W-1:0] gamma_slope);
    load_entry(sb.table_index(q), knot, chi, gamma, chi_slope, gamma_slope);
    query(q);
  endtask

  task automatic drain();
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_small_chi(logic [V_W-1:0] v);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    sb.set_small_chi(v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic receive_results();
    int unsigned stall;
    forever begin
      stall = idle_cycles(rx_idle);
      @(negedge clk);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata, m_axis_tuser);
    end
  endtask

  function automatic logic [Q_W-1:0] rand_segment_q();
    case ($urandom_range(4, 0))
      0: return Q_W'($urandom_range(Q_2, Q_TINY_MAX + 1));
      1: return Q_W'($urandom_range(Q_22, Q_2 + 1));
      2: return Q_W'($urandom_range(Q_222, Q_22 + 1));
      3: return Q_W'($urandom_range(Q_2222, Q_222 + 1));
      default: return Q_W'($urandom_range(Q_HUGE - 1, Q_2222 + 1));
    endcase
  endfunction

  function automatic logic [Q_W-1:0] boundary_q();
    logic [Q_W-1:0] b;
    case ($urandom_range(5, 0))
      0: b = Q_TINY_MAX;
      1: b = Q_2;
      2: b = Q_22;
      3: b = Q_222;
      4: b = Q_2222;
      default: b = Q_HUGE - 31'd1;
    endcase
    return b + Q_W'($urandom_range(1, 0));
  endfunction

  task automatic random_item();
    int unsigned sel;
    longint k;
    sel = $urandom_range(99, 0);
    if (sel < 6) begin
      query(Q_W'($urandom_range(Q_TINY_MAX, 0)));
    end else if (sel < 12) begin
      query(Q_W'($urandom_range(31'h7FFF_FFFF, Q_HUGE)));
    end else if (sel < 19) begin
      load_entry(EIX_W'($urandom_range(DEPTH - 1, 0)), Q_W'($urandom()), $urandom(),
                 $urandom(), rand_slope(), rand_slope());
    end else if (sel == 19) begin
      load_entry(EIX_W'($urandom_range(16383, DEPTH)), Q_W'($urandom()), $urandom(),
                 $urandom(), $urandom(), $urandom());
    end else if (sel < 26) begin
      query(boundary_q());
    end else if (sel < 45) begin
      k = longint'(last_q) + longint'($urandom_range(8191, 0)) - 4096;
      if (k < 0) k = 0;
      query(Q_W'(k));
    end else begin
      query(rand_segment_q());
    end
  endtask

  initial begin
    logic [V_W-1:0] phase_cfg [4];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = MODE_QUERY;
    m_axis_tready = 1'b0;
    last_q = '0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    sb = new();
    phase_cfg = '{32'h7FFF_FFFF, 32'h8000_0000, $urandom(), 32'h0};
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    fork
      receive_results();
    join_none

    query(0);
    query(Q_TINY_MAX);
    query(Q_HUGE);
    query(31'h7FFF_FFFF);
    query_with_entry(Q_TINY_MAX + 31'd1, '0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h8000_0000);
    query_with_entry(Q_2, 31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h8000_0000);
    // rounding ties go toward plus infinity
    query_with_entry(31'(300 * Q_ONE), 31'(300 * Q_ONE - 32768), '0, '0, 32'd1, 32'hFFFF_FFFF);
    query_with_entry(31'(301 * Q_ONE), 31'(301 * Q_ONE + 32768), '0, '0, 32'd1, 32'hFFFF_FFFF);
    query(Q_2 + 31'd1);
    query(Q_22);
    query(Q_22 + 31'd1);
    query(Q_222);
    query(Q_222 + 31'd1);
    query(Q_2222);
    query(Q_2222 + 31'd1);
    query(Q_HUGE - 31'd1);
    // loads past the end of the table are dropped
    load_entry(14'h3FFF, 31'h7FFF_FFFF, '1, '1, '1, '1);
    load_entry(EIX_W'(DEPTH), '0, '0, '0, '0, '0);

    for (int p = 0; p < 4; p++) begin
      write_small_chi(phase_cfg[p]);
      tx_idle = (p == 1 || p == 2);
      rx_idle = (p == 1 || p == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) random_item();
    end

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    drain();
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
